/* sv/nlpp_pkg.sv */
// Package with the shared types and constants of the NLRI prefix parser.
`timescale 1ns / 1ps

package nlpp_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned ADDR_W = 32;
	localparam logic [BYTE_W-1:0] MAX_PREFIX_LEN = 8'd32;

	typedef struct packed {
		logic [2:0]        remaining;
		logic [1:0]        taken;
		logic [BYTE_W-1:0] length;
		logic [ADDR_W-1:0] acc;
	} parse_state_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] length;
		logic [ADDR_W-1:0] address;
		logic              truncated;
		logic              message_end;
	} prefix_result_t;

	localparam parse_state_t STATE_CLEAR = '{
		remaining: 3'd0,
		taken:     2'd0,
		length:    '0,
		acc:       '0
	};

endpackage

/* sv/nlpp_step.sv */
// Next-state and result logic for one byte of the prefix list.
`timescale 1ns / 1ps

module nlpp_step
	import nlpp_pkg::*;
(
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              last_byte,
	input  parse_state_t      state_cur,
	output parse_state_t      state_nxt,
	output prefix_result_t    result
);

	logic [8:0]        need_sum;
	logic [2:0]        need;
	logic [2:0]        rem_dec;
	logic [ADDR_W-1:0] placed;
	logic [ADDR_W-1:0] acc_new;

	always_comb begin
		need_sum = {1'b0, data_byte} + 9'd7;
		if (data_byte == '0 || data_byte > MAX_PREFIX_LEN) begin
			need = 3'd0;
		end else begin
			need = need_sum[5:3];
		end

		case (state_cur.taken)
			2'd0:    placed = {data_byte, 24'd0};
			2'd1:    placed = {8'd0, data_byte, 16'd0};
			2'd2:    placed = {16'd0, data_byte, 8'd0};
			default: placed = {24'd0, data_byte};
		endcase
		acc_new = state_cur.acc | placed;
		rem_dec = state_cur.remaining - 3'd1;
	end

	always_comb begin
		state_nxt = state_cur;
		result = '{valid: 1'b0, length: '0, address: '0, truncated: 1'b0, message_end: 1'b0};

		if (state_cur.remaining == 3'd0) begin
			if (need == 3'd0) begin
				result = '{valid: 1'b1, length: data_byte, address: '0,
					truncated: 1'b0, message_end: last_byte};
			end else if (last_byte) begin
				result = '{valid: 1'b1, length: data_byte, address: '0,
					truncated: 1'b1, message_end: 1'b1};
				state_nxt = STATE_CLEAR;
			end else begin
				state_nxt = '{remaining: need, taken: 2'd0, length: data_byte, acc: '0};
			end
		end else begin
			if (rem_dec == 3'd0) begin
				result = '{valid: 1'b1, length: state_cur.length, address: acc_new,
					truncated: 1'b0, message_end: last_byte};
				state_nxt = STATE_CLEAR;
			end else if (last_byte) begin
				result = '{valid: 1'b1, length: state_cur.length, address: '0,
					truncated: 1'b1, message_end: 1'b1};
				state_nxt = STATE_CLEAR;
			end else begin
				state_nxt = '{remaining: rem_dec, taken: state_cur.taken + 2'd1,
					length: state_cur.length, acc: acc_new};
			end
		end
	end

endmodule

/* sv/nlri_prefix_parser.sv */
// Top level of the NLRI IPv4 prefix parser: input register, step logic, result register.
`timescale 1ns / 1ps
// An accepted word waits in the input register; its result, if any, is written to the result
// register as the word advances. Throughput: one word per cycle, set by the single state update
// per word; the input stalls only while the result register is held and the waiting word
// yields a result. Reset (arst_n low, asynchronous) empties both registers and leaves the
// parser expecting a length byte.

module nlri_prefix_parser
	import nlpp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              last_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] prefix_length,
	output logic [ADDR_W-1:0] prefix_address,
	output logic              truncated,
	output logic              message_end
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	parse_state_t      state_q;
	parse_state_t      state_nxt;
	prefix_result_t    step_res;
	prefix_result_t    res_s2;
	logic              out_free;
	logic              advance;

	nlpp_step u_step (
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.state_cur (state_q),
		.state_nxt (state_nxt),
		.result    (step_res)
	);

	assign out_free = !res_s2.valid || !out_stall;
	assign advance  = valid_s1 && (out_free || !step_res.valid);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= STATE_CLEAR;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else if (out_free) begin
			if (advance && step_res.valid) begin
				res_s2 <= step_res;
			end else begin
				res_s2.valid <= 1'b0;
			end
		end
	end

	assign out_valid      = res_s2.valid;
	assign prefix_length  = res_s2.length;
	assign prefix_address = res_s2.address;
	assign truncated      = res_s2.truncated;
	assign message_end    = res_s2.message_end;

`ifndef ASSERT_OFF
	a_trunc_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && truncated |-> message_end)
		else $error("truncated result without message end");

	a_trunc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && truncated |-> prefix_address == '0)
		else $error("truncated result carries an address");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.remaining <= 3'd4)
		else $error("octet count out of range");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && step_res.valid && res_s2.valid && out_stall)
		else $error("input stalled without a blocked result");
`endif

endmodule

/* sim/nlri_prefix_parser_tb.sv */
// Self-checking testbench for the NLRI IPv4 prefix parser with random handshake idling.
`timescale 1ns / 1ps

module nlri_prefix_parser_tb;
	import nlpp_pkg::*;

	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              last;
		bit                typed;
		prefix_result_t    result;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [BYTE_W-1:0] data_byte;
	logic              last_byte;
	logic              out_valid;
	logic              out_stall;
	logic [BYTE_W-1:0] prefix_length;
	logic [ADDR_W-1:0] prefix_address;
	logic              truncated;
	logic              message_end;

	parse_state_t   shadow_parse = STATE_CLEAR;
	prefix_result_t pending_prefixes[$];
	int             mismatches = 0;
	int             words_sent = 0;
	int             send_calm = 0;
	int             take_calm = 0;

	// The typed rows cover zero and oversized lengths and messages that end inside a prefix.
	stim_row_t directed_rows[25] = '{
		'{8'd0,   1'b0, 1'b1, '{1'b1, 8'd0,   32'd0, 1'b0, 1'b0}},
		'{8'd0,   1'b1, 1'b1, '{1'b1, 8'd0,   32'd0, 1'b0, 1'b1}},
		'{8'd33,  1'b0, 1'b1, '{1'b1, 8'd33,  32'd0, 1'b0, 1'b0}},
		'{8'd255, 1'b1, 1'b1, '{1'b1, 8'd255, 32'd0, 1'b0, 1'b1}},
		'{8'd32,  1'b0, 1'b0, '0},
		'{8'hFF,  1'b0, 1'b0, '0},
		'{8'hA5,  1'b0, 1'b0, '0},
		'{8'h5A,  1'b0, 1'b0, '0},
		'{8'h00,  1'b1, 1'b0, '0},
		'{8'd1,   1'b0, 1'b0, '0},
		'{8'h80,  1'b0, 1'b0, '0},
		'{8'd9,   1'b0, 1'b0, '0},
		'{8'hC0,  1'b0, 1'b0, '0},
		'{8'h01,  1'b1, 1'b0, '0},
		'{8'd17,  1'b0, 1'b0, '0},
		'{8'h0A,  1'b0, 1'b0, '0},
		'{8'h0B,  1'b0, 1'b0, '0},
		'{8'h0C,  1'b0, 1'b0, '0},
		'{8'd24,  1'b1, 1'b1, '{1'b1, 8'd24,  32'd0, 1'b1, 1'b1}},
		'{8'd25,  1'b0, 1'b0, '0},
		'{8'hFF,  1'b0, 1'b0, '0},
		'{8'hFF,  1'b1, 1'b1, '{1'b1, 8'd25,  32'd0, 1'b1, 1'b1}},
		'{8'd16,  1'b0, 1'b0, '0},
		'{8'h12,  1'b0, 1'b0, '0},
		'{8'h34,  1'b1, 1'b0, '0}
	};

	nlri_prefix_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.prefix_length(prefix_length),
		.prefix_address(prefix_address),
		.truncated(truncated),
		.message_end(message_end)
	);

	always #1 clk = ~clk;

	function automatic bit decode_prefix_byte(input logic [BYTE_W-1:0] b, input logic l,
			output prefix_result_t r);
		logic [2:0] need;
		logic [1:0] pos;
		r = '0;
		r.valid = 1'b1;
		if (shadow_parse.remaining == 3'd0) begin
			if (b == '0 || b > MAX_PREFIX_LEN) begin
				need = 3'd0;
			end else begin
				need = 3'((int'(b) + 7) / 8);
			end
			r.length = b;
			if (need == 3'd0) begin
				r.message_end = l;
				return 1'b1;
			end
			if (l) begin
				r.truncated = 1'b1;
				r.message_end = 1'b1;
				shadow_parse = STATE_CLEAR;
				return 1'b1;
			end
			shadow_parse.length = b;
			shadow_parse.remaining = need;
			shadow_parse.taken = 2'd0;
			shadow_parse.acc = '0;
			return 1'b0;
		end
		pos = shadow_parse.taken;
		shadow_parse.acc = shadow_parse.acc | (ADDR_W'(b) << ((3 - int'(pos)) * 8));
		shadow_parse.taken = pos + 2'd1;
		shadow_parse.remaining = shadow_parse.remaining - 3'd1;
		r.length = shadow_parse.length;
		if (shadow_parse.remaining == 3'd0) begin
			r.address = shadow_parse.acc;
			r.message_end = l;
			shadow_parse = STATE_CLEAR;
			return 1'b1;
		end
		if (l) begin
			r.truncated = 1'b1;
			r.message_end = 1'b1;
			shadow_parse = STATE_CLEAR;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Entered and left at a falling edge.
	task automatic send_word(input logic [BYTE_W-1:0] b, input logic l, input bit typed,
			input prefix_result_t typed_result);
		int             gap;
		prefix_result_t r;
		if (send_calm > 0) begin
			send_calm--;
			gap = 0;
		end else begin
			gap = $urandom_range(0, 5);
			if ($urandom_range(0, 19) == 0)
				send_calm = $urandom_range(10, 40);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		do @(posedge clk); while (in_stall);
		if (decode_prefix_byte(b, l, r)) begin
			if (typed)
				r = typed_result;
			pending_prefixes = {pending_prefixes, r};
		end
		words_sent++;
		@(negedge clk);
	endtask

	initial begin
		int               kind;
		int               prefixes;
		int               len;
		int               need;
		int               cut;
		logic [BYTE_W-1:0] msg[$];
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed_rows[i])
			send_word(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
				directed_rows[i].result);
		while (words_sent < 1025) begin
			kind = $urandom_range(0, 9);
			msg.delete();
			if (kind == 9) begin
				repeat ($urandom_range(1, 8))
					send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
			end else begin
				prefixes = $urandom_range(1, 4);
				repeat (prefixes) begin
					case ($urandom_range(0, 19))
						0: len = 0;
						1: len = $urandom_range(33, 255);
						default: len = $urandom_range(1, 32);
					endcase
					need = (len == 0 || len > 32) ? 0 : (len + 7) / 8;
					msg = {msg, 8'(len)};
					repeat (need)
						msg = {msg, 8'($urandom_range(0, 255))};
				end
				// A broken message is cut short, usually inside a prefix.
				if (kind >= 7) begin
					cut = $urandom_range(1, msg.size());
					while (msg.size() > cut)
						void'(msg.pop_back());
				end
				foreach (msg[i])
					send_word(msg[i], i == msg.size() - 1, 1'b0, '0);
			end
		end
		in_valid <= 1'b0;
		while (pending_prefixes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int             gap;
		prefix_result_t want;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (take_calm > 0) begin
				take_calm--;
				gap = 0;
			end else begin
				gap = $urandom_range(0, 5);
				if ($urandom_range(0, 19) == 0)
					take_calm = $urandom_range(10, 40);
			end
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			if (pending_prefixes.size() == 0) begin
				$error("unexpected result: length %0d address %h", prefix_length, prefix_address);
				mismatches++;
			end else begin
				want = pending_prefixes.pop_front();
				if (prefix_length !== want.length) begin
					$error("prefix_length: expected %0d, got %0d", want.length, prefix_length);
					mismatches++;
				end
				if (prefix_address !== want.address) begin
					$error("prefix_address: expected %h, got %h", want.address, prefix_address);
					mismatches++;
				end
				if (truncated !== want.truncated) begin
					$error("truncated: expected %b, got %b", want.truncated, truncated);
					mismatches++;
				end
				if (message_end !== want.message_end) begin
					$error("message_end: expected %b, got %b", want.message_end, message_end);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
